[src/mvt_pkg.sv]
`default_nettype none
package mvt_pkg;

    localparam int ELEM_W     = 32;
    localparam int LANES      = 4;
    localparam int LANE_W     = 2;
    localparam int ROW_IDX_W  = 2;
    localparam int DIM_DEF    = 4;
    localparam int FRAC_DEF   = 16;

    localparam int IN_DATA_W  = ((ROW_IDX_W + LANES * ELEM_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((LANES * ELEM_W + 7) / 8) * 8;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XFORM = 1'b1;

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct packed {
        logic              mul_en;
        logic              last;
        logic [LANE_W-1:0] lane;
    } mac_ctl_t;

    typedef struct packed {
        logic              valid;
        logic [LANE_W-1:0] lane;
        elem_t             value;
        logic              clip;
    } mac_res_t;

endpackage
`default_nettype wire

[src/matrix_vector_transform_core.sv]
`default_nettype none
// Holds a DIM x DIM matrix of signed fixed-point elements (FRAC_BITS fraction bits),
// all zero after reset. An item with s_tuser = 0 writes the matrix row named by its
// row index (an index at or beyond DIM is dropped) and gives no result.
// An item with s_tuser = 1 carries a vector and gives one result: element i is the
// saturated sum over j of (row i element j * vector element j) >>> FRAC_BITS, and
// m_tuser flags any clipped element; with DIM = 3 the fourth element is zero. A single
// 32x32 multiplier and accumulator serve every product, one per cycle in S_MUL; each
// matrix row is first read from the row RAM in S_RD. A transform runs S_RD and S_MUL
// for each row, then S_FIN, and then waits in S_OUT until the result register is free.
// s_tready is low while a transform is in progress.
module matrix_vector_transform_core #(
    parameter int DIM       = mvt_pkg::DIM_DEF,
    parameter int FRAC_BITS = mvt_pkg::FRAC_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // row_index[1:0], elem_zero, elem_one, elem_two, elem_three, zero fill
    input  wire logic [mvt_pkg::IN_DATA_W-1:0]  s_tdata,
    // opcode
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // out_zero, out_one, out_two, out_three
    output logic      [mvt_pkg::OUT_DATA_W-1:0] m_tdata,
    // saturated
    output logic                                m_tuser
);
    import mvt_pkg::*;

    localparam int ROW_W   = $clog2(DIM);
    localparam int ROW_BUS = DIM * ELEM_W;
    localparam logic [ROW_W-1:0] LAST_IDX = ROW_W'(DIM - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] col_reg, col_next;
    logic [DIM-1:0]   row_valid_reg;
    logic             rd_valid_reg;
    elem_t            vec_reg [DIM];
    elem_t            res_reg [LANES];
    logic             sat_reg;
    logic             m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic             m_tuser_reg;

    logic               s_xfer;
    logic               load_we;
    logic [ROW_W-1:0]   load_row;
    logic [ROW_BUS-1:0] ram_rdata;
    logic               ram_re;
    logic               out_free;
    logic [OUT_DATA_W-1:0] out_pack;
    elem_t              op_a;
    mac_ctl_t           mac_ctl;
    mac_res_t           mac_res;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign load_row = s_tdata[ROW_W-1:0];
    assign load_we  = s_xfer && (s_tuser == OP_LOAD)
                      && ({1'b0, s_tdata[ROW_IDX_W-1:0]} < (ROW_IDX_W + 1)'(DIM));
    assign ram_re   = (state_reg == S_RD);
    assign out_free = !m_tvalid_reg || m_tready;

    mvt_ram #(
        .WIDTH(ROW_BUS),
        .DEPTH(DIM)
    ) u_row_ram (
        .aclk (aclk),
        .we   (load_we),
        .waddr(load_row),
        .wdata(s_tdata[ROW_IDX_W +: ROW_BUS]),
        .re   (ram_re),
        .raddr(row_reg),
        .rdata(ram_rdata)
    );

    assign op_a = rd_valid_reg ? elem_t'(ram_rdata[col_reg * ELEM_W +: ELEM_W]) : '0;

    assign mac_ctl.mul_en = (state_reg == S_MUL);
    assign mac_ctl.last   = (col_reg == LAST_IDX);
    assign mac_ctl.lane   = LANE_W'(row_reg);

    mvt_mac #(
        .FRAC_BITS(FRAC_BITS),
        .DIM      (DIM)
    ) u_mac (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (mac_ctl),
        .op_a   (op_a),
        .op_b   (vec_reg[col_reg]),
        .res    (mac_res)
    );

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_xfer && (s_tuser == OP_XFORM)) begin
                    state_next = S_RD;
                    row_next   = '0;
                end
            end
            S_RD: begin
                state_next = S_MUL;
                col_next   = '0;
            end
            S_MUL: begin
                col_next = col_reg + 1'b1;
                if (col_reg == LAST_IDX) begin
                    if (row_reg == LAST_IDX) begin
                        state_next = S_FIN;
                    end else begin
                        state_next = S_RD;
                        row_next   = row_reg + 1'b1;
                    end
                end
            end
            S_FIN: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_pack = '0;
        for (int i = 0; i < LANES; i++) begin
            out_pack[i * ELEM_W +: ELEM_W] = res_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (load_we) begin
                row_valid_reg[load_row] <= 1'b1;
            end
            if (ram_re) begin
                rd_valid_reg <= row_valid_reg[row_reg];
            end
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && (s_tuser == OP_XFORM)) begin
            for (int j = 0; j < DIM; j++) begin
                vec_reg[j] <= s_tdata[ROW_IDX_W + j * ELEM_W +: ELEM_W];
            end
            for (int i = 0; i < LANES; i++) begin
                res_reg[i] <= '0;
            end
            sat_reg <= 1'b0;
        end else if (mac_res.valid) begin
            res_reg[mac_res.lane] <= mac_res.value;
            sat_reg               <= sat_reg | mac_res.clip;
        end
        if (state_reg == S_OUT && out_free) begin
            m_tdata_reg <= out_pack;
            m_tuser_reg <= sat_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_xform_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tuser == OP_XFORM) |=> state_reg == S_RD)
        else $error("transform transfer did not start the row sequence");

    a_load_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tuser == OP_LOAD) |=> state_reg == S_IDLE)
        else $error("load transfer left the idle state");

    a_mac_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_res.valid |-> (state_reg == S_RD || state_reg == S_FIN))
        else $error("row sum finished outside a transform");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result presented without a finished transform");

endmodule
`default_nettype wire

[src/mvt_ram.sv]
`default_nettype none
module mvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

[src/mvt_mac.sv]
`default_nettype none
module mvt_mac #(
    parameter int FRAC_BITS = mvt_pkg::FRAC_DEF,
    parameter int DIM       = mvt_pkg::DIM_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mvt_pkg::mac_ctl_t ctl,
    input  wire mvt_pkg::elem_t    op_a,
    input  wire mvt_pkg::elem_t    op_b,
    output mvt_pkg::mac_res_t      res
);
    import mvt_pkg::*;

    localparam int PROD_W  = 2 * ELEM_W;
    localparam int SHIFT_W = PROD_W - FRAC_BITS;
    localparam int ACC_W   = SHIFT_W + $clog2(DIM);

    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    mac_ctl_t                  ctl_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [SHIFT_W-1:0] term;
    logic signed [ACC_W-1:0]   sum;
    logic                      fits;

    assign prod_next = op_a * op_b;
    assign term      = prod_reg[PROD_W-1:FRAC_BITS];
    assign sum       = acc_reg + ACC_W'(term);
    assign fits      = (&sum[ACC_W-1:ELEM_W-1]) | ~(|sum[ACC_W-1:ELEM_W-1]);

    always_comb begin
        acc_next = acc_reg;
        if (ctl_reg.mul_en) begin
            acc_next = ctl_reg.last ? '0 : sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
            acc_reg <= '0;
        end else begin
            ctl_reg <= ctl;
            acc_reg <= acc_next;
        end
        if (ctl.mul_en) begin
            prod_reg <= prod_next;
        end
    end

    always_comb begin
        res.valid = ctl_reg.mul_en && ctl_reg.last;
        res.lane  = ctl_reg.lane;
        res.clip  = !fits;
        if (fits) begin
            res.value = sum[ELEM_W-1:0];
        end else begin
            res.value = sum[ACC_W-1] ? ELEM_MIN : ELEM_MAX;
        end
    end

endmodule
`default_nettype wire

[bench/tb_matrix_vector_transform_core.sv]
`default_nettype none
module tb_matrix_vector_transform_core;
    import mvt_pkg::*;

    localparam int DIM  = DIM_DEF;
    localparam int FRAC = FRAC_DEF;

    typedef logic [LANES-1:0][ELEM_W-1:0] vec_t;

    typedef struct packed {
        logic clip;
        vec_t lane;
    } xform_t;

    class transform_checker;
        elem_t  matrix [LANES][LANES];
        xform_t expected_q [$];
        int     errors;
        int     loads;
        int     xforms;
        int     checked;
        int     clipped;

        function new();
            for (int i = 0; i < LANES; i++) begin
                for (int j = 0; j < LANES; j++) begin
                    matrix[i][j] = '0;
                end
            end
            errors  = 0;
            loads   = 0;
            xforms  = 0;
            checked = 0;
            clipped = 0;
        endfunction

        function xform_t transform_vector(vec_t v);
            xform_t                 r;
            logic signed [63:0]     prod;
            logic signed [65:0]     acc;
            r = '0;
            for (int i = 0; i < LANES; i++) begin
                acc = '0;
                if (i < DIM) begin
                    for (int j = 0; j < DIM; j++) begin
                        prod = matrix[i][j] * elem_t'(v[j]);
                        acc  = acc + (prod >>> FRAC);
                    end
                    if (acc > ELEM_MAX) begin
                        acc    = ELEM_MAX;
                        r.clip = 1'b1;
                    end else if (acc < ELEM_MIN) begin
                        acc    = ELEM_MIN;
                        r.clip = 1'b1;
                    end
                end
                r.lane[i] = acc[ELEM_W-1:0];
            end
            return r;
        endfunction

        function void note_item(logic op, logic [ROW_IDX_W-1:0] row, vec_t v);
            if (op == OP_LOAD) begin
                loads++;
                if (row < DIM) begin
                    for (int j = 0; j < DIM; j++) begin
                        matrix[row][j] = elem_t'(v[j]);
                    end
                end
            end else begin
                xforms++;
                expected_q.push_back(transform_vector(v));
            end
        endfunction

        function void check_output(vec_t got, logic sat);
            xform_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h sat %b",
                         $time, got, sat);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want.clip) begin
                clipped++;
            end
            for (int i = 0; i < LANES; i++) begin
                if (got[i] !== want.lane[i]) begin
                    $display("%0t: element %0d mismatch, expected %0d, actual %0d",
                             $time, i, $signed(want.lane[i]), $signed(got[i]));
                    errors++;
                end
            end
            if (sat !== want.clip) begin
                $display("%0t: saturated flag mismatch, expected %b, actual %b",
                         $time, want.clip, sat);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    transform_checker sb;
    bit               rst_done;
    bit               no_idle;
    bit               hold_rx;

    localparam elem_t ONE = 32'sh0001_0000;

    matrix_vector_transform_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
    end

    always #10 aclk = ~aclk;

    function automatic vec_t lanes4(elem_t e0, elem_t e1, elem_t e2, elem_t e3);
        return {e3, e2, e1, e0};
    endfunction

    function automatic elem_t rand_elem();
        int k;
        k = 0;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                k = $urandom_range(0, 524288);
                return elem_t'(k - 262144);
            end
            3, 4: begin
                k = $urandom_range(0, 1 << 25);
                return elem_t'(k - (1 << 24));
            end
            5, 6, 7: return elem_t'($urandom);
            8: begin
                case ($urandom_range(0, 6))
                    0: return ELEM_MAX;
                    1: return ELEM_MIN;
                    2: return elem_t'(0);
                    3: return elem_t'(-1);
                    4: return elem_t'(1);
                    5: return ONE;
                    default: return -ONE;
                endcase
            end
            default: return elem_t'($urandom) >>> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [ROW_IDX_W-1:0] row, input vec_t v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_DATA_W'({v, row});
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, row, v);
        @(negedge aclk);
    endtask

    task automatic send_random(input int count, input int load_pct);
        vec_t v;
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < LANES; i++) begin
                v[i] = rand_elem();
            end
            send_item(($urandom_range(0, 99) < load_pct) ? OP_LOAD : OP_XFORM,
                      ROW_IDX_W'($urandom_range(0, 3)), v);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int stall;
        m_tready = 1'b0;
        wait (rst_done);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (hold_rx) begin
                hold_rx = 1'b0;
                stall   = 400;
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_output(vec_t'(m_tdata), m_tuser);
            @(negedge aclk);
        end
    end

    initial begin
        #20_000_000;
        $display("** matrix_vector_transform_core: FAILED **");
        $finish;
    end

    initial begin
        sb       = new();
        rst_done = 1'b0;
        no_idle  = 1'b0;
        hold_rx  = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn  = 1'b1;
        rst_done = 1'b1;
        @(negedge aclk);

        send_item(OP_XFORM, 2'd0, lanes4(1, 2, 3, 4));
        for (int r = 0; r < LANES; r++) begin
            send_item(OP_LOAD, ROW_IDX_W'(r),
                      lanes4(r == 0 ? ONE : 0, r == 1 ? ONE : 0,
                             r == 2 ? ONE : 0, r == 3 ? ONE : 0));
        end
        send_item(OP_XFORM, 2'd3, lanes4(ELEM_MAX, ELEM_MIN, -1, 1));
        send_item(OP_LOAD, 2'd0, lanes4(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
        send_item(OP_LOAD, 2'd1, lanes4(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
        send_item(OP_LOAD, 2'd2, lanes4(ELEM_MAX, ELEM_MIN, -1, 0));
        send_item(OP_LOAD, 2'd3, lanes4(-1, -1, -1, -1));
        send_item(OP_XFORM, 2'd0, lanes4(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
        send_item(OP_XFORM, 2'd1, lanes4(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
        send_item(OP_XFORM, 2'd2, lanes4(-1, -1, -1, -1));
        send_item(OP_XFORM, 2'd0, lanes4(1, 1, 1, 1));
        send_item(OP_XFORM, 2'd0, lanes4(0, 0, 0, 0));
        send_item(OP_XFORM, 2'd0, lanes4(ONE, -ONE, ONE, -ONE));
        send_item(OP_LOAD, 2'd2, lanes4(32'sh5555_5555, 32'shAAAA_AAAA,
                                        32'sh5555_5555, 32'shAAAA_AAAA));
        send_item(OP_XFORM, 2'd1, lanes4(32'shAAAA_AAAA, 32'sh5555_5555,
                                         32'shAAAA_AAAA, 32'sh5555_5555));
        send_item(OP_XFORM, 2'd3, lanes4(ELEM_MIN, ELEM_MAX, 0, ELEM_MIN));

        send_random(650, 30);

        hold_rx = 1'b1;
        send_random(40, 10);
        wait_drained();

        no_idle = 1'b1;
        send_random(400, 30);
        no_idle = 1'b0;

        wait_drained();
        send_random(590, 35);

        wait_drained();
        repeat (60) @(posedge aclk);

        $display("Run covered %0d row loads and %0d transforms; %0d results checked, %0d clipped.",
                 sb.loads, sb.xforms, sb.checked, sb.clipped);
        if (sb.errors == 0) begin
            $display("** matrix_vector_transform_core: PASSED **");
        end else begin
            $display("** matrix_vector_transform_core: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
src/mvt_pkg.sv
src/mvt_ram.sv
src/mvt_mac.sv
src/matrix_vector_transform_core.sv
bench/tb_matrix_vector_transform_core.sv
